// ===== rtl/core/sc2a_pkg.sv =====
// Shared types, constants and key tables for the scancode to ASCII key FIFO.
// No dependencies; the controller, the top level and the testbench use this package.
`timescale 1ns / 1ps

package sc2a_pkg;

    // FIFO geometry: one slot always stays empty, so FifoDepth-1 events fit
    localparam int FifoDepth = 64;
    localparam int PtrW      = $clog2(FifoDepth);

    // Set-1 details
    localparam int           MapLen         = 58;
    localparam logic [6:0]   ShiftCodeReset = 7'h2A;

    // Request codes
    localparam logic ReqByte = 1'b0;
    localparam logic ReqRead = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scancode;
    } t_req;

    typedef struct packed {
        logic       key_valid;
        logic       key_pressed;
        logic [6:0] key_ascii;
        logic [6:0] key_scancode;
        logic       keys_pending;
        logic       dropped;
    } t_key;

    // One stored event: ascii in the upper half, scancode in the lower
    typedef struct packed {
        logic [6:0] ascii;
        logic [6:0] code;
    } t_event;

    localparam int EventW = $bits(t_event);

    // Event RAM access from the controller
    typedef struct packed {
        logic            we;
        logic [PtrW-1:0] waddr;
        t_event          wdata;
        logic            re;
        logic [PtrW-1:0] raddr;
    } t_ram_ctl;

    // Per-beat status that rides along with the RAM read
    typedef struct packed {
        logic strobe;
        logic pop;
        logic pending;
        logic dropped;
    } t_step_status;

    localparam logic [6:0] PlainMap [0:MapLen-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] UpperMap [0:MapLen-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Translate a press code; codes past the table give NUL
    function automatic logic [6:0] map_ascii(input logic [6:0] code, input logic shifted);
        logic [5:0] idx;
        logic [6:0] res;
        idx = code[5:0];
        res = 7'h00;
        if (code < 7'(MapLen)) begin
            res = shifted ? UpperMap[idx] : PlainMap[idx];
        end
        return res;
    endfunction

    // Ring pointer advance with wrap at the last slot
    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/core/sc2a_event_ram.sv =====
// Simple dual-port RAM for the key event store, one write and one read port.
// Read data is registered. Standalone, no package use.
`timescale 1ns / 1ps

module sc2a_event_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sc2a_ctrl.sv =====
// Controller: shift tracking, key translation, FIFO pointers and RAM access.
// Depends on sc2a_pkg for types, tables and pointer helpers.
`timescale 1ns / 1ps

module sc2a_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  sc2a_pkg::t_req        i_req,
    input  logic                  i_cfg_we,
    input  logic [6:0]            i_cfg_wdata,
    output sc2a_pkg::t_ram_ctl    o_ram,
    output sc2a_pkg::t_step_status o_status
);

    logic [sc2a_pkg::PtrW-1:0] r_rp, n_rp;
    logic [sc2a_pkg::PtrW-1:0] r_wp, n_wp;
    logic                      r_shift, n_shift;
    logic [6:0]                r_shift_code;
    sc2a_pkg::t_step_status    r_status, n_status;

    logic                      is_byte, is_release, is_shift, push_req;
    logic                      full, empty, do_push, do_pop;
    logic [sc2a_pkg::PtrW-1:0] wp_next;

    // decode the beat and work out the pointer moves
    always_comb begin
        is_byte    = (i_req.req_type == sc2a_pkg::ReqByte);
        is_release = i_req.scancode[7];
        is_shift   = (i_req.scancode[6:0] == r_shift_code);
        push_req   = is_byte && !is_release && !is_shift;
        wp_next    = sc2a_pkg::bump(r_wp);
        full       = (wp_next == r_rp);
        empty      = (r_rp == r_wp);
        do_push    = i_accept && push_req && !full;
        do_pop     = i_accept && (i_req.req_type == sc2a_pkg::ReqRead) && !empty;

        n_wp    = do_push ? wp_next : r_wp;
        n_rp    = do_pop ? sc2a_pkg::bump(r_rp) : r_rp;

        n_shift = r_shift;
        if (i_accept && is_byte && is_shift) begin
            n_shift = !is_release;
        end

        n_status.strobe  = i_accept;
        n_status.pop     = do_pop;
        n_status.pending = (n_rp != n_wp);
        n_status.dropped = i_accept && push_req && full;
    end

    // RAM access: push writes at the write pointer, pop reads at the read pointer
    always_comb begin
        o_ram.we          = do_push;
        o_ram.waddr       = r_wp;
        o_ram.wdata.ascii = sc2a_pkg::map_ascii(i_req.scancode[6:0], r_shift);
        o_ram.wdata.code  = i_req.scancode[6:0];
        o_ram.re          = do_pop;
        o_ram.raddr       = r_rp;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_wp     <= '0;
            r_shift  <= 1'b0;
            r_status <= '0;
        end else begin
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_shift  <= n_shift;
            r_status <= n_status;
        end
    end

    // shift key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_code <= sc2a_pkg::ShiftCodeReset;
        end else if (i_cfg_we) begin
            r_shift_code <= i_cfg_wdata;
        end
    end

    assign o_status = r_status;

endmodule

// ===== rtl/core/scancode_to_ascii_key_fifo.sv =====
// Top level of the set-1 scancode to ASCII key event FIFO.
// Depends on sc2a_pkg, sc2a_ctrl and sc2a_event_ram.
`timescale 1ns / 1ps

// Every beat (a scancode byte or a read request) gives exactly one result,
// shown on o_key with o_strobe for one cycle, in the cycle after the beat is
// taken. busy stays low, so a new beat may be issued every cycle; the delay
// comes from the registered read of the event RAM. The receiver
// has no way to stall, so each result must be captured in its strobe cycle.
// The FIFO holds up to 63 events; a press arriving when it is full is
// discarded and flagged by dropped. There is no clearing pass after reset.

module scancode_to_ascii_key_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sc2a_pkg::t_req   i_req,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    output logic             o_strobe,
    output sc2a_pkg::t_key   o_key
);

    logic                    accept;
    sc2a_pkg::t_ram_ctl      ram_ctl;
    sc2a_pkg::t_step_status  status;
    sc2a_pkg::t_event        rd_event;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    sc2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram       (ram_ctl),
        .o_status    (status)
    );

    sc2a_event_ram #(
        .DEPTH (sc2a_pkg::FifoDepth),
        .WIDTH (sc2a_pkg::EventW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_ctl.waddr),
        .i_wdata (ram_ctl.wdata),
        .i_re    (ram_ctl.re),
        .i_raddr (ram_ctl.raddr),
        .o_rdata (rd_event)
    );

    // result assembly: popped fields only when a stored event came out
    always_comb begin
        o_strobe           = status.strobe;
        o_key.key_valid    = status.pop;
        o_key.key_pressed  = status.pop;
        o_key.key_ascii    = status.pop ? rd_event.ascii : 7'h00;
        o_key.key_scancode = status.pop ? rd_event.code : 7'h00;
        o_key.keys_pending = status.pending;
        o_key.dropped      = status.dropped;
    end

    // each taken beat gives a result in the next cycle, and only then
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("missing result after accepted beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result without accepted beat");

    // a pop only follows a read request, a drop only a byte
    a_pop_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.key_valid |-> $past(i_req.req_type == sc2a_pkg::ReqRead) && !o_key.dropped)
        else $error("pop on a byte beat");

    // a lost press means the FIFO was full and stays non-empty
    a_drop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.dropped |-> o_key.keys_pending && o_strobe)
        else $error("drop reported with FIFO empty");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for scancode_to_ascii_key_fifo: directed table, then random beats.
// Depends on sc2a_pkg and the RTL of the block; predicts every result with its own key FIFO.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned TimeoutNs  = 4_000_000;
    localparam int          KeyMapSize = 58;
    localparam int          PhaseCount = 8;
    localparam int          PhaseBeats = 190;
    localparam int          CfgRandom  = -1;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_TYPING
    } t_burst;

    // One row of the directed table; lit is checked only when has_lit is set
    typedef struct {
        sc2a_pkg::t_req  req;
        logic            has_lit;
        sc2a_pkg::t_key  lit;
    } t_row;

    // One expected result: predicted key plus an optional literal from the table
    typedef struct {
        sc2a_pkg::t_key  pred;
        logic            has_lit;
        sc2a_pkg::t_key  lit;
    } t_key_expect;

    // Set-1 key tables, unshifted and shifted
    localparam logic [6:0] PlainKeys [KeyMapSize] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] ShiftedKeys [KeyMapSize] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           start       = 1'b0;
    logic           busy;
    sc2a_pkg::t_req i_req       = '0;
    logic           i_cfg_we    = 1'b0;
    logic [6:0]     i_cfg_wdata = '0;
    logic           o_strobe;
    sc2a_pkg::t_key o_key;

    // Literal expectation travelling with the beat on the request port
    logic           lit_on  = 1'b0;
    sc2a_pkg::t_key lit_key = '0;

    // Predicted key FIFO and shift state
    logic [13:0] stored_keys [sc2a_pkg::FifoDepth];
    int unsigned key_rd;
    int unsigned key_wr;
    logic        shift_down;
    logic [6:0]  shift_key;

    t_key_expect key_q [$];
    t_row        dir_rows [$];
    int          fails = 0;

    scancode_to_ascii_key_fifo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_key       (o_key)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #(TimeoutNs);
        $display("FAIL scancode_to_ascii_key_fifo");
        $finish;
    end

    // Next key result from one accepted beat; updates the predicted FIFO
    function automatic sc2a_pkg::t_key predict_key(sc2a_pkg::t_req r);
        sc2a_pkg::t_key k;
        logic [6:0]     code;
        logic [6:0]     ascii;
        int unsigned    nxt;
        k = '0;
        code = r.scancode[6:0];
        if (r.req_type == sc2a_pkg::ReqByte) begin
            if (r.scancode[7]) begin
                // release: only the shift key matters
                if (code == shift_key) shift_down = 1'b0;
            end else if (code == shift_key) begin
                shift_down = 1'b1;
            end else begin
                ascii = 7'h00;
                if (code < KeyMapSize)
                    ascii = shift_down ? ShiftedKeys[code[5:0]] : PlainKeys[code[5:0]];
                nxt = (key_wr + 1) % sc2a_pkg::FifoDepth;
                if (nxt != key_rd) begin
                    stored_keys[key_wr[sc2a_pkg::PtrW-1:0]] = {ascii, code};
                    key_wr = nxt;
                end else begin
                    k.dropped = 1'b1;
                end
            end
        end else if (key_rd != key_wr) begin
            k.key_valid    = 1'b1;
            k.key_pressed  = 1'b1;
            k.key_ascii    = stored_keys[key_rd[sc2a_pkg::PtrW-1:0]][13:7];
            k.key_scancode = stored_keys[key_rd[sc2a_pkg::PtrW-1:0]][6:0];
            key_rd = (key_rd + 1) % sc2a_pkg::FifoDepth;
        end
        k.keys_pending = (key_rd != key_wr);
        return k;
    endfunction

    function automatic void check_key(sc2a_pkg::t_key got, sc2a_pkg::t_key want, string src);
        if (got.key_valid !== want.key_valid) begin
            $error("%s key_valid: expected %0d, got %0d", src, want.key_valid, got.key_valid);
            fails++;
        end
        if (got.key_pressed !== want.key_pressed) begin
            $error("%s key_pressed: expected %0d, got %0d", src, want.key_pressed,
                   got.key_pressed);
            fails++;
        end
        if (got.key_ascii !== want.key_ascii) begin
            $error("%s key_ascii: expected 'h%02h, got 'h%02h", src, want.key_ascii,
                   got.key_ascii);
            fails++;
        end
        if (got.key_scancode !== want.key_scancode) begin
            $error("%s key_scancode: expected 'h%02h, got 'h%02h", src, want.key_scancode,
                   got.key_scancode);
            fails++;
        end
        if (got.keys_pending !== want.keys_pending) begin
            $error("%s keys_pending: expected %0d, got %0d", src, want.keys_pending,
                   got.keys_pending);
            fails++;
        end
        if (got.dropped !== want.dropped) begin
            $error("%s dropped: expected %0d, got %0d", src, want.dropped, got.dropped);
            fails++;
        end
    endfunction

    // Monitor: check the result of the previous beat, then predict the beat taken now
    always @(posedge i_clk) begin : key_monitor
        t_key_expect e;
        if (!i_rst_n) begin
            key_rd     = 0;
            key_wr     = 0;
            shift_down = 1'b0;
            shift_key  = sc2a_pkg::ShiftCodeReset;
        end else begin
            if (o_strobe === 1'b1) begin
                if (key_q.size() == 0) begin
                    $error("key result with no beat outstanding");
                    fails++;
                end else begin
                    e = key_q.pop_front();
                    check_key(o_key, e.pred, "predicted");
                    if (e.has_lit) check_key(o_key, e.lit, "table");
                end
            end
            if (start && !busy) begin
                e.pred    = predict_key(i_req);
                e.has_lit = lit_on;
                e.lit     = lit_key;
                key_q.push_back(e);
            end
            // new shift code takes effect after this edge
            if (i_cfg_we) shift_key = i_cfg_wdata;
        end
    end

    function automatic sc2a_pkg::t_key key_lit(logic valid, logic [6:0] ascii,
                                               logic [6:0] code, logic pending);
        sc2a_pkg::t_key k;
        k = '0;
        k.key_valid    = valid;
        k.key_pressed  = valid;
        k.key_ascii    = ascii;
        k.key_scancode = code;
        k.keys_pending = pending;
        return k;
    endfunction

    function automatic void add_row(logic rt, logic [7:0] code, logic has,
                                    sc2a_pkg::t_key lit);
        t_row row;
        row.req.req_type = rt;
        row.req.scancode = code;
        row.has_lit      = has;
        row.lit          = lit;
        dir_rows.push_back(row);
    endfunction

    // Random beat shaped by the kind of burst in progress
    function automatic sc2a_pkg::t_req pick_beat(t_burst kind);
        sc2a_pkg::t_req r;
        int unsigned    read_pct;
        int unsigned    roll;
        case (kind)
            BURST_FILL:  read_pct = 5;
            BURST_DRAIN: read_pct = 70;
            default:     read_pct = 35;
        endcase
        r.req_type = sc2a_pkg::ReqByte;
        roll = $urandom_range(99);
        if ($urandom_range(99) < read_pct) begin
            // scancode is don't-care on reads, keep it toggling
            r.req_type = sc2a_pkg::ReqRead;
            r.scancode = 8'($urandom_range(255));
        end else if (roll < 8) begin
            r.scancode = {1'b0, shift_key};
        end else if (roll < 16) begin
            r.scancode = {1'b1, shift_key};
        end else if (roll < 26) begin
            r.scancode = {1'b1, 7'($urandom_range(127))};
        end else if (roll < 34) begin
            r.scancode = 8'($urandom_range(255));
        end else if (roll < 44) begin
            r.scancode = {1'b0, 7'($urandom_range(127))};
        end else begin
            r.scancode = 8'($urandom_range(KeyMapSize - 1));
        end
        return r;
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic issue(sc2a_pkg::t_req r, logic has, sc2a_pkg::t_key lit);
        start   <= 1'b1;
        i_req   <= r;
        lit_on  <= has;
        lit_key <= lit;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(int unsigned pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has been seen
    task automatic drain();
        start <= 1'b0;
        while (key_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_shift_code(logic [6:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int          cfg_plan [PhaseCount];
        int unsigned idle_plan [4];
        int          sent;
        int          burst_len;
        t_burst      kind;

        cfg_plan  = '{127, 0, CfgRandom, 42, 54, CfgRandom, 16, 0};
        idle_plan = '{0, 64, 0, 26};

        // Directed table, shift code at its reset value
        add_row(sc2a_pkg::ReqRead, 8'hFF, 1'b1, key_lit(0, 7'h00, 7'h00, 0));  // empty read
        add_row(sc2a_pkg::ReqByte, 8'h80, 1'b1, key_lit(0, 7'h00, 7'h00, 0));  // plain release
        add_row(sc2a_pkg::ReqByte, 8'hFF, 1'b1, key_lit(0, 7'h00, 7'h00, 0));
        add_row(sc2a_pkg::ReqByte, 8'hAA, 1'b1, key_lit(0, 7'h00, 7'h00, 0));  // shift up
        add_row(sc2a_pkg::ReqByte, 8'h2A, 1'b1, key_lit(0, 7'h00, 7'h00, 0));  // shift down
        add_row(sc2a_pkg::ReqByte, 8'h1E, 1'b1, key_lit(0, 7'h00, 7'h00, 1));
        add_row(sc2a_pkg::ReqRead, 8'h00, 1'b1, key_lit(1, 7'h41, 7'h1E, 0));  // 'A'
        add_row(sc2a_pkg::ReqByte, 8'hAA, 1'b1, key_lit(0, 7'h00, 7'h00, 0));  // shift up
        add_row(sc2a_pkg::ReqByte, 8'h1E, 1'b1, key_lit(0, 7'h00, 7'h00, 1));
        add_row(sc2a_pkg::ReqRead, 8'h55, 1'b1, key_lit(1, 7'h61, 7'h1E, 0));  // 'a'
        add_row(sc2a_pkg::ReqByte, 8'h00, 1'b1, key_lit(0, 7'h00, 7'h00, 1));  // code 0, NUL
        add_row(sc2a_pkg::ReqByte, 8'h39, 1'b1, key_lit(0, 7'h00, 7'h00, 1));  // last entry
        add_row(sc2a_pkg::ReqByte, 8'h3A, 1'b1, key_lit(0, 7'h00, 7'h00, 1));  // past table
        add_row(sc2a_pkg::ReqByte, 8'h7F, 1'b1, key_lit(0, 7'h00, 7'h00, 1));
        add_row(sc2a_pkg::ReqRead, 8'hAA, 1'b1, key_lit(1, 7'h00, 7'h00, 1));
        add_row(sc2a_pkg::ReqRead, 8'h00, 1'b1, key_lit(1, 7'h20, 7'h39, 1));
        add_row(sc2a_pkg::ReqRead, 8'hFF, 1'b1, key_lit(1, 7'h00, 7'h3A, 1));
        add_row(sc2a_pkg::ReqRead, 8'h01, 1'b1, key_lit(1, 7'h00, 7'h7F, 0));
        add_row(sc2a_pkg::ReqRead, 8'h80, 1'b1, key_lit(0, 7'h00, 7'h00, 0));
        add_row(sc2a_pkg::ReqByte, 8'h2A, 1'b0, '0);
        add_row(sc2a_pkg::ReqByte, 8'h0D, 1'b0, '0);  // '+' while shifted
        add_row(sc2a_pkg::ReqByte, 8'h02, 1'b0, '0);
        add_row(sc2a_pkg::ReqRead, 8'h00, 1'b0, '0);
        add_row(sc2a_pkg::ReqRead, 8'h00, 1'b0, '0);
        add_row(sc2a_pkg::ReqByte, 8'hAA, 1'b0, '0);

        // Hold synchronous reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].has_lit, dir_rows[i].lit);
        drain();

        // Random phases, each under a shift code written anew and an idle pattern from a list of four
        for (int p = 0; p < PhaseCount; p++) begin
            write_shift_code((cfg_plan[p] == CfgRandom) ? 7'($urandom_range(127))
                                                        : 7'(cfg_plan[p]));
            sent = 0;
            while (sent < PhaseBeats) begin
                kind      = t_burst'($urandom_range(2));
                burst_len = $urandom_range(16, 90);
                if (burst_len > PhaseBeats - sent) burst_len = PhaseBeats - sent;
                for (int j = 0; j < burst_len; j++) begin
                    idle_gap(idle_plan[p % 4]);
                    issue(pick_beat(kind), 1'b0, '0);
                end
                sent += burst_len;
            end
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (fails == 0) begin
            $display("PASS scancode_to_ascii_key_fifo");
        end else begin
            $display("FAIL scancode_to_ascii_key_fifo");
        end
        $finish;
    end

endmodule

// ===== scancode_to_ascii_key_fifo.f =====
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_event_ram.sv
rtl/core/sc2a_ctrl.sv
rtl/core/scancode_to_ascii_key_fifo.sv
tb/sv/tb_top.sv
